>>> design/tchb_pkg.sv
// Shared types and constants for the tagged chain hash join build block.
// Used by the front, queue, back and top level modules; depends on nothing.
`timescale 1ns / 1ps

package tchb_pkg;

   // Field widths of the request and response transactions.
   localparam int ADDR_W     = 48;
   localparam int HASH_W     = 64;
   localparam int TAG_W      = 16;
   localparam int IDX_W      = 12;
   localparam int LOG2_W     = 4;

   // Largest table size exponent that the size register may select.
   localparam int LOG2_LIMIT = 12;

   // Reset value of the table size register.
   localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd12;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Request kinds.
   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   // Part of a classified transaction that does not depend on the table size.
   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] addr;
      logic [TAG_W-1:0]  tag;
   } item_type;

   // Status that the back reports to the front.
   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

>>> design/tchb_front.sv
// Front end: accepts request transactions, holds the table size register and
// computes the bucket of each transaction. Depends on tchb_pkg.
`timescale 1ns / 1ps

module tchb_front
   import tchb_pkg::*;
#(
   parameter int BUCKET_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [ADDR_W-1:0]      req_entry_address,
   input  logic [HASH_W-1:0]      req_hash,
   input  logic [IDX_W-1:0]       req_bucket_index,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LOG2_W-1:0]      csr_data,
   input  back_status_type        status,
   input  logic                   q_full,
   output logic                   q_push,
   output item_type               q_item,
   output logic [BUCKET_BITS-1:0] q_bucket
);

   // Size exponent ceiling and width that holds both index forms.
   localparam int LgLimit = (BUCKET_BITS < LOG2_LIMIT) ? BUCKET_BITS : LOG2_LIMIT;
   localparam int WideW   = (BUCKET_BITS > IDX_W) ? BUCKET_BITS : IDX_W;

   logic [LOG2_W-1:0]      table_log2_ff;
   logic [LOG2_W-1:0]      log2_used;
   logic [BUCKET_BITS-1:0] used_mask;
   logic [WideW-1:0]       read_idx_wide;

   // Takes every write; user must make writes only while idle (unenforced).
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_log2_ff <= LOG2_RESET;
      end else if (csr_valid && csr_ready) begin
         table_log2_ff <= csr_data;
      end
   end

   // Saturate the size exponent and build the bucket mask.
   assign log2_used = (table_log2_ff > LOG2_W'(LgLimit)) ? LOG2_W'(LgLimit) : table_log2_ff;
   assign used_mask = ~({BUCKET_BITS{1'b1}} << log2_used);

   // Reads are masked to the physical table only.
   assign read_idx_wide = WideW'(req_bucket_index);

   // No transaction is taken while the table is being cleared.
   assign req_stall = q_full || status.clearing;
   assign q_push    = req_valid && !req_stall;

   // Classify the transaction and pick its bucket.
   always_comb begin
      q_item.kind = kind_type'(req_kind);
      q_item.addr = req_entry_address;
      q_item.tag  = req_hash[HASH_W-1 -: TAG_W];
      case (kind_type'(req_kind))
         KIND_INSERT: q_bucket = req_hash[BUCKET_BITS-1:0] & used_mask;
         KIND_READ:   q_bucket = read_idx_wide[BUCKET_BITS-1:0];
         default:     q_bucket = read_idx_wide[BUCKET_BITS-1:0];
      endcase
   end

endmodule

>>> design/tchb_queue.sv
// Short queue that decouples the front from the back.
// Carries classified transactions and their bucket; depends on tchb_pkg.
`timescale 1ns / 1ps

module tchb_queue
   import tchb_pkg::*;
#(
   parameter int BUCKET_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  item_type               push_item,
   input  logic [BUCKET_BITS-1:0] push_bucket,
   output logic                   full,
   input  logic                   pop,
   output item_type               pop_item,
   output logic [BUCKET_BITS-1:0] pop_bucket,
   output logic                   empty
);

   localparam int PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountW = $clog2(QUEUE_DEPTH + 1);

   item_type               item_ff   [QUEUE_DEPTH];
   logic [BUCKET_BITS-1:0] bucket_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]        wr_ptr_ff;
   logic [PtrW-1:0]        rd_ptr_ff;
   logic [CountW-1:0]      count_ff;
   logic [PtrW-1:0]        wr_ptr_in;
   logic [PtrW-1:0]        rd_ptr_in;
   logic [CountW-1:0]      count_in;

   assign full       = (count_ff == CountW'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign pop_item   = item_ff[rd_ptr_ff];
   assign pop_bucket = bucket_ff[rd_ptr_ff];

   // Pointer wrap and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff]   <= push_item;
         bucket_ff[wr_ptr_ff] <= push_bucket;
      end
   end

endmodule

>>> design/tchb_back.sv
// Back end: owns the bucket head memory, clears it after reset, performs the
// read-modify-write of each transaction and holds the response register.
// Depends on tchb_pkg.
`timescale 1ns / 1ps

module tchb_back
   import tchb_pkg::*;
#(
   parameter int BUCKET_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  item_type               q_item,
   input  logic [BUCKET_BITS-1:0] q_bucket,
   output logic                   q_pop,
   output back_status_type        status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ADDR_W-1:0]      rsp_entry_address_out,
   output logic [HASH_W-1:0]      rsp_link_value
);

   localparam int Depth = 2 ** BUCKET_BITS;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   state_type              state_ff;
   state_type              state_in;
   logic [BUCKET_BITS-1:0] clr_ff;
   item_type               item_ff;
   logic [BUCKET_BITS-1:0] bucket_ff;
   logic [HASH_W-1:0]      head_ff;
   logic                   rsp_valid_ff;
   logic [ADDR_W-1:0]      rsp_addr_ff;
   logic [HASH_W-1:0]      rsp_link_ff;
   logic [HASH_W-1:0]      mem [Depth];

   logic                   mem_we;
   logic [BUCKET_BITS-1:0] mem_waddr;
   logic [HASH_W-1:0]      mem_wdata;
   logic                   load_rsp;
   logic [TAG_W-1:0]       new_tag;

   assign status.clearing       = (state_ff == ST_CLEAR);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_entry_address_out = rsp_addr_ff;
   assign rsp_link_value        = rsp_link_ff;

   // The new tag accumulates the hash tag bits into the old head's tag.
   assign new_tag = head_ff[HASH_W-1 -: TAG_W] | item_ff.tag;

   // Next state and memory write control.
   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_ff == {BUCKET_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // Finish only once the response register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
               if (item_ff.kind == KIND_INSERT) begin
                  mem_we    = 1'b1;
                  mem_waddr = bucket_ff;
                  mem_wdata = {new_tag, item_ff.addr};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, clear counter, captured transaction and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (q_pop) begin
            item_ff   <= q_item;
            bucket_ff <= q_bucket;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
            rsp_link_ff  <= head_ff;
            rsp_addr_ff  <= (item_ff.kind == KIND_INSERT) ? item_ff.addr : '0;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Bucket head memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_LOOKUP) begin
         head_ff <= mem[bucket_ff];
      end
   end

endmodule

>>> design/tagged_chain_hash_join_build_top.sv
// An accepted request passes through the queue, then the back end's idle,
// lookup and update states, which read, update and write the bucket head
// memory; the back end takes no new one until that one is done.
// Reset: synchronous, active high. After reset the head memory is cleared at
// one bucket per cycle, all 2**BUCKET_BITS buckets, with req_stall held high.
// Depends on tchb_pkg, tchb_front, tchb_queue and tchb_back.
`timescale 1ns / 1ps

module tagged_chain_hash_join_build_top
   import tchb_pkg::*;
#(
   parameter int BUCKET_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [ADDR_W-1:0] req_entry_address,
   input  logic [HASH_W-1:0] req_hash,
   input  logic [IDX_W-1:0]  req_bucket_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_entry_address_out,
   output logic [HASH_W-1:0] rsp_link_value,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LOG2_W-1:0] csr_data
);

   back_status_type        status;
   logic                   q_push;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_empty;
   item_type               push_item;
   item_type               pop_item;
   logic [BUCKET_BITS-1:0] push_bucket;
   logic [BUCKET_BITS-1:0] pop_bucket;

   // Accept and classify transactions.
   tchb_front #(
      .BUCKET_BITS(BUCKET_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_entry_address (req_entry_address),
      .req_hash          (req_hash),
      .req_bucket_index  (req_bucket_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .status            (status),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_item            (push_item),
      .q_bucket          (push_bucket)
   );

   // Decoupling queue.
   tchb_queue #(
      .BUCKET_BITS(BUCKET_BITS)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_item   (push_item),
      .push_bucket (push_bucket),
      .full        (q_full),
      .pop         (q_pop),
      .pop_item    (pop_item),
      .pop_bucket  (pop_bucket),
      .empty       (q_empty)
   );

   // Table update and response.
   tchb_back #(
      .BUCKET_BITS(BUCKET_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_empty               (q_empty),
      .q_item                (pop_item),
      .q_bucket              (pop_bucket),
      .q_pop                 (q_pop),
      .status                (status),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_entry_address_out (rsp_entry_address_out),
      .rsp_link_value        (rsp_link_value)
   );

endmodule

>>> design/tchb_checker.sv
// Port-level checks for the tagged chain hash join build top level, and the
// bind that attaches them. Depends on tchb_pkg and the top level.
`timescale 1ns / 1ps

module tchb_checker
   import tchb_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [ADDR_W-1:0] rsp_entry_address_out,
   input logic [HASH_W-1:0] rsp_link_value
);

   // Reset starts the clear pass and empties the response register.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (req_stall && !rsp_valid))
      else $error("Reset did not stall requests or clear the response.");

   // The clear pass still blocks requests once reset has been released.
   a_clear_holds: assert property (@(posedge clock)
      (reset ##1 !reset) |=> req_stall)
      else $error("Requests accepted while the table was being cleared.");

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_entry_address_out) && $stable(rsp_link_value)))
      else $error("Stalled response changed.");

   // A response is withdrawn only after it was taken.
   a_rsp_taken: assert property (@(posedge clock) disable iff (reset)
      ($fell(rsp_valid) && !$past(reset)) |-> !$past(rsp_stall))
      else $error("Response dropped without being taken.");

endmodule

bind tagged_chain_hash_join_build_top tchb_checker u_tchb_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_entry_address_out (rsp_entry_address_out),
   .rsp_link_value        (rsp_link_value)
);
